// ===== hdl/spgm_pkg.sv =====
// shared types, constants and gain helpers for the stereo pan/gain mixer
// used by spgm_lane, spgm_mix and stereo_pan_gain_mixer; no dependencies
`default_nettype none

package spgm_pkg;

    localparam int GAIN_BITS = 16;
    localparam int GAIN_FRAC = 15;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'h8000;

    // per-voice control that travels down the pipeline beside the lanes
    typedef struct packed {
        logic active;
        logic first;
        logic last;
    } t_ctl;

    // volumes above unity clamp to unity
    function automatic logic [GAIN_BITS-1:0] sat_volume(input logic [GAIN_BITS-1:0] vol);
        return (vol > GAIN_ONE) ? GAIN_ONE : vol;
    endfunction

    // left pan factor: unity when panned left, 1 - pan otherwise
    function automatic logic [GAIN_BITS-1:0] pan_left(input logic signed [GAIN_BITS-1:0] pan);
        logic [GAIN_BITS:0] diff;
        diff = {1'b0, GAIN_ONE} - {1'b0, pan};
        return pan[GAIN_BITS-1] ? GAIN_ONE : diff[GAIN_BITS-1:0];
    endfunction

    // right pan factor: unity when panned right, 1 + pan otherwise
    function automatic logic [GAIN_BITS-1:0] pan_right(input logic signed [GAIN_BITS-1:0] pan);
        logic [GAIN_BITS:0] sum;
        sum = {1'b0, GAIN_ONE} + {pan[GAIN_BITS-1], pan};
        return (!pan[GAIN_BITS-1] && (pan != '0)) ? GAIN_ONE : sum[GAIN_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/spgm_lane.sv =====
// one channel lane: gain = volume * pan factor, then sample * gain
// two register stages, one multiplier each; uses spgm_pkg
`default_nettype none

module spgm_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_en,
    input  wire  signed [SAMPLE_BITS-1:0]         i_sample,
    input  wire         [spgm_pkg::GAIN_BITS-1:0] i_volume,
    input  wire         [spgm_pkg::GAIN_BITS-1:0] i_pan_gain,
    output logic signed [SAMPLE_BITS+spgm_pkg::GAIN_BITS:0] o_product
);
    import spgm_pkg::*;

    logic        [2*GAIN_BITS-1:0]          r_gain_prod;
    logic signed [SAMPLE_BITS-1:0]          r_sample;
    logic        [GAIN_BITS-1:0]            gain;
    logic signed [SAMPLE_BITS+GAIN_BITS:0]  n_product;
    logic signed [SAMPLE_BITS+GAIN_BITS:0]  r_product;

    // gain product is at most 2^30, so the unity bit lands in bit 15 of the slice
    assign gain      = r_gain_prod[GAIN_FRAC+GAIN_BITS-1:GAIN_FRAC];
    assign n_product = r_sample * $signed({1'b0, gain});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gain_prod <= i_volume * i_pan_gain;
            r_sample    <= i_sample;
            r_product   <= n_product;
        end
    end

    assign o_product = r_product;

endmodule

`default_nettype wire

// ===== hdl/spgm_mix.sv =====
// merge stage: saturating accumulate of both lanes and the output register
// uses spgm_pkg for the control struct and gain fraction
`default_nettype none

module spgm_mix #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                             i_clk,
    input  wire                                             i_rst_n,
    input  wire                                             i_advance,
    input  wire                                             i_valid,
    input  spgm_pkg::t_ctl                                  i_ctl,
    input  wire  signed [SAMPLE_BITS+spgm_pkg::GAIN_BITS:0] i_left_prod,
    input  wire  signed [SAMPLE_BITS+spgm_pkg::GAIN_BITS:0] i_right_prod,
    input  wire                                             i_out_ready,
    output logic                                            o_stall,
    output logic                                            o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]                   o_left,
    output logic signed [SAMPLE_BITS-1:0]                   o_right
);
    import spgm_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_acc_l, r_acc_r, n_acc_l, n_acc_r;
    logic signed [SAMPLE_BITS-1:0] r_out_l, r_out_r;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] scaled_l, scaled_r;
    logic                          process;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_add(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b
    );
        logic signed [SAMPLE_BITS:0] s;
        s = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
        if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) begin
            return s[SAMPLE_BITS] ? SMIN : SMAX;
        end
        return s[SAMPLE_BITS-1:0];
    endfunction

    // floor shift by the gain fraction; gain <= 1 keeps it inside the sample range
    assign scaled_l = i_left_prod[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];
    assign scaled_r = i_right_prod[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];

    assign process = i_valid && i_advance;
    // a frame end cannot retire while the output register still holds one
    assign o_stall = i_valid && i_ctl.last && r_out_valid && !i_out_ready;

    always_comb begin
        n_acc_l = i_ctl.first ? '0 : r_acc_l;
        n_acc_r = i_ctl.first ? '0 : r_acc_r;
        if (i_ctl.active) begin
            n_acc_l = sat_add(n_acc_l, scaled_l);
            n_acc_r = sat_add(n_acc_r, scaled_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_l     <= '0;
            r_acc_r     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (process) begin
                r_acc_l <= n_acc_l;
                r_acc_r <= n_acc_r;
            end
            if (process && i_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && i_ctl.last) begin
            r_out_l <= n_acc_l;
            r_out_r <= n_acc_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left      = r_out_l;
    assign o_right     = r_out_r;

endmodule

`default_nettype wire

// ===== hdl/stereo_pan_gain_mixer.sv =====
// stereo_pan_gain_mixer: linear-pan voice mixer, top level
// two spgm_lane instances (left, right) feeding the spgm_mix merge stage
//
// usage: one slave-side transaction per voice carries its stereo sample pair,
// volume and pan; tuser flags whether the voice is active and whether it starts
// a frame, and tlast marks the frame's last voice. a master-side transaction
// carrying the saturated left/right mix follows each voice with tlast set.
// throughput: one voice per cycle. each lane has two multiplier stages (gain,
// then sample scaling) and the merge stage does one saturating add per cycle,
// so a voice is taken every cycle while the pipeline keeps moving.
// the last voice passes both lane register stages, then the output register makes the mixed frame valid.
// stall: the result sits in an output register; voices keep being accepted
// while it waits, and the whole pipeline holds only when the next frame's last
// voice reaches the accumulator with the output register still full.
// reset (synchronous, active low) clears both accumulators, the pipeline
// valids and the output valid; mixing without a frame start adds onto zero.
`default_nettype none

module stereo_pan_gain_mixer #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // left_sample, right_sample, voice_volume, voice_pan, zero fill
    input  wire  [((2*SAMPLE_BITS+32+7)/8)*8-1:0] i_s_axis_tdata,
    // voice_active, first_voice
    input  wire  [1:0]                            i_s_axis_tuser,
    input  wire                                   i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // mixed_left, mixed_right, zero fill
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    o_m_axis_tdata
);
    import spgm_pkg::*;

    localparam int OUT_W   = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int VOL_LSB = 2*SAMPLE_BITS;
    localparam int PAN_LSB = 2*SAMPLE_BITS+GAIN_BITS;

    logic signed [SAMPLE_BITS-1:0]         in_left, in_right;
    logic        [GAIN_BITS-1:0]           in_volume;
    logic signed [GAIN_BITS-1:0]           in_pan;
    logic        [GAIN_BITS-1:0]           volume, pan_l, pan_r;
    logic signed [SAMPLE_BITS+GAIN_BITS:0] prod_l, prod_r;
    t_ctl                                  in_ctl, r_ctl1, r_ctl2;
    logic                                  r_v1, r_v2;
    logic                                  w_advance, stall;
    logic                                  out_valid;
    logic signed [SAMPLE_BITS-1:0]         mixed_l, mixed_r;

    assign in_left   = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_right  = i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_volume = i_s_axis_tdata[VOL_LSB+GAIN_BITS-1:VOL_LSB];
    assign in_pan    = i_s_axis_tdata[PAN_LSB+GAIN_BITS-1:PAN_LSB];

    assign in_ctl.active = i_s_axis_tuser[0];
    assign in_ctl.first  = i_s_axis_tuser[1];
    assign in_ctl.last   = i_s_axis_tlast;

    assign volume = sat_volume(in_volume);
    assign pan_l  = pan_left(in_pan);
    assign pan_r  = pan_right(in_pan);

    assign w_advance       = !stall;
    assign o_s_axis_tready = w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_advance) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_ctl1 <= in_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    spgm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
        .i_clk      (i_clk),
        .i_en       (w_advance),
        .i_sample   (in_left),
        .i_volume   (volume),
        .i_pan_gain (pan_l),
        .o_product  (prod_l)
    );

    spgm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
        .i_clk      (i_clk),
        .i_en       (w_advance),
        .i_sample   (in_right),
        .i_volume   (volume),
        .i_pan_gain (pan_r),
        .o_product  (prod_r)
    );

    spgm_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_valid      (r_v2),
        .i_ctl        (r_ctl2),
        .i_left_prod  (prod_l),
        .i_right_prod (prod_r),
        .i_out_ready  (i_m_axis_tready),
        .o_stall      (stall),
        .o_out_valid  (out_valid),
        .o_left       (mixed_l),
        .o_right      (mixed_r)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = OUT_W'({mixed_r, mixed_l});

    // a frame end that retires must show up on the output next cycle
    a_frame_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_ctl2.last && w_advance) |=> o_m_axis_tvalid)
        else $error("retired frame end did not raise output valid");

    // output valid only rises from a retiring frame end
    a_no_spurious_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_v2 && r_ctl2.last))
        else $error("output valid rose without a frame end");

    // a held pipeline keeps its first stage occupied
    a_hold_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_advance) |=> r_v1)
        else $error("stage one lost its voice during a stall");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for stereo_pan_gain_mixer: voice transactions in, mixed frames out
// expected frames come from a local linear-pan mix predictor; depends on spgm_pkg and the rtl
`default_nettype none

module testbench;

    localparam int  SBITS      = 16;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  HOLD_LEN   = 300;
    localparam int  RAND_VOICES = 450;
    localparam longint UNITY   = longint'(spgm_pkg::GAIN_ONE);
    localparam longint SMAX    = (64'sd1 <<< (SBITS - 1)) - 1;
    localparam longint SMIN    = -SMAX - 1;

    typedef struct {
        logic                    active;
        logic signed [SBITS-1:0] left;
        logic signed [SBITS-1:0] right;
        logic [15:0]             volume;
        logic signed [15:0]      pan;
        logic                    first;
        logic                    last;
    } t_voice;

    typedef struct {
        logic signed [SBITS-1:0] left;
        logic signed [SBITS-1:0] right;
    } t_frame;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    s_valid = 1'b0;
    logic [63:0]             s_data  = '0;
    logic [1:0]              s_user  = '0;
    logic                    s_last  = 1'b0;
    logic                    m_ready = 1'b0;
    wire                     s_ready;
    wire                     m_valid;
    wire [31:0]              m_data;

    t_voice voice_q[$];
    t_frame frame_q[$];
    t_voice cur_voice;

    longint mix_left  = 0;
    longint mix_right = 0;

    bit     in_fire = 1'b0;
    bit     quiet   = 1'b0;
    bit     hold_done = 1'b0;
    int     send_gap  = 0;
    int     stall_cnt = 0;
    int     idle_cycles = 0;
    int     cycle_cnt = 0;
    int     voices_in = 0;
    int     frames_out = 0;
    int     clip_cnt = 0;
    int     n_err = 0;

    stereo_pan_gain_mixer #(.SAMPLE_BITS(SBITS)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // left_sample, right_sample, voice_volume, voice_pan
        .i_s_axis_tdata  (s_data),
        // voice_active, first_voice
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // mixed_left, mixed_right
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip16(input longint s);
        if (s > SMAX) begin
            clip_cnt++;
            return SMAX;
        end
        if (s < SMIN) begin
            clip_cnt++;
            return SMIN;
        end
        return s;
    endfunction

    // linear pan law, gains and products floored by the arithmetic shift
    task automatic mix_voice(input t_voice v);
        longint vol, pan, pl, pr, gl, gr;
        t_frame f;
        vol = longint'(v.volume);
        if (vol > UNITY) vol = UNITY;
        pan = longint'(v.pan);
        if (v.first) begin
            mix_left  = 0;
            mix_right = 0;
        end
        if (v.active) begin
            pl = (pan < 0) ? UNITY : UNITY - pan;
            pr = (pan > 0) ? UNITY : UNITY + pan;
            gl = (vol * pl) >>> 15;
            gr = (vol * pr) >>> 15;
            mix_left  = clip16(mix_left  + ((longint'(v.left)  * gl) >>> 15));
            mix_right = clip16(mix_right + ((longint'(v.right) * gr) >>> 15));
        end
        if (v.last) begin
            f.left  = mix_left[SBITS-1:0];
            f.right = mix_right[SBITS-1:0];
            frame_q.insert(frame_q.size(), f);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7fff;
        if (r == 1) return 16'h8000;
        if (r == 2) return 16'($urandom_range(0, 15)) - 16'd8;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_volume();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 16'($urandom_range(32769, 65535));
        if (r == 2) return 16'h8000;
        if (r == 3) return 16'h0000;
        return 16'($urandom_range(0, 32768));
    endfunction

    function automatic logic [15:0] pick_pan();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r == 2) return 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic add_voice(input logic act, input logic [15:0] l, input logic [15:0] r,
                             input logic [15:0] vol, input logic [15:0] pan,
                             input logic first, input logic last);
        t_voice v;
        v.active = act;
        v.left   = l;
        v.right  = r;
        v.volume = vol;
        v.pan    = pan;
        v.first  = first;
        v.last   = last;
        voice_q.insert(voice_q.size(), v);
    endtask

    task automatic add_random_frame();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
            add_voice($urandom_range(0, 4) != 0, pick_sample(), pick_sample(),
                      pick_volume(), pick_pan(), k == 0, k == n - 1);
        end
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            add_voice($urandom_range(0, 1), pick_sample(), pick_sample(), pick_volume(),
                      pick_pan(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end
    endtask

    // driver: presents the next queued voice once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (voice_q.size() > 0) begin
                cur_voice = voice_q.pop_front();
                s_data  <= {cur_voice.pan, cur_voice.volume, cur_voice.right, cur_voice.left};
                s_user  <= {cur_voice.first, cur_voice.active};
                s_last  <= cur_voice.last;
                s_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    always @(negedge i_clk) begin
        if (!hold_done && voices_in >= 150) begin
            hold_done = 1'b1;
            stall_cnt = HOLD_LEN;
        end
        if (stall_cnt > 0) begin
            stall_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= i_rst_n;
            stall_cnt = pick_gap();
        end
    end

    // monitor: predicts on accepted voices, checks accepted frames
    always @(posedge i_clk) begin
        t_frame e;
        in_fire = i_rst_n && s_valid && s_ready;
        if (in_fire) begin
            mix_voice(cur_voice);
            voices_in++;
        end
        if (i_rst_n && m_valid && m_ready) begin
            frames_out++;
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected frame left %0d right %0d", $time,
                         $signed(m_data[15:0]), $signed(m_data[31:16]));
                n_err++;
            end else begin
                e = frame_q.pop_front();
                if (m_data[15:0] !== e.left) begin
                    $display("%0t: mismatch mixed_left expected %0d got %0d", $time,
                             e.left, $signed(m_data[15:0]));
                    n_err++;
                end
                if (m_data[31:16] !== e.right) begin
                    $display("%0t: mismatch mixed_right expected %0d got %0d", $time,
                             e.right, $signed(m_data[31:16]));
                    n_err++;
                end
            end
        end
    end

    // watchdog on transaction progress, also flips between gapped and full-rate stretches
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt % 128 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (in_fire || (m_valid && m_ready) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no frame started: adds onto the reset value
        add_voice(1, 16'h1234, 16'hedcb, 16'h8000, 16'h0000, 0, 1);
        // unity volume, centered, full scale
        add_voice(1, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 1, 1);
        // volume above one, hard left and hard right
        add_voice(1, 16'h8000, 16'h7fff, 16'hffff, 16'h8000, 1, 1);
        add_voice(1, 16'h7fff, 16'h7fff, 16'h8001, 16'h7fff, 1, 1);
        // zero volume
        add_voice(1, 16'h7fff, 16'h8000, 16'h0000, 16'h1000, 1, 1);
        // positive clip over two voices, negative clip over three
        add_voice(1, 16'h7fff, 16'h7000, 16'h8000, 16'h0000, 1, 0);
        add_voice(1, 16'h7fff, 16'h7000, 16'h8000, 16'h0000, 0, 1);
        add_voice(1, 16'h8000, 16'h9000, 16'h8000, 16'h0000, 1, 0);
        add_voice(1, 16'h8000, 16'h9000, 16'hc000, 16'hf000, 0, 0);
        add_voice(1, 16'h8001, 16'h8000, 16'h8000, 16'h0800, 0, 1);
        // inactive voices still clear and emit
        add_voice(0, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 1, 1);
        add_voice(1, 16'h4000, 16'hc000, 16'h6000, 16'h2000, 1, 0);
        add_voice(0, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 0, 1);
        // continues on the previous totals without a start
        add_voice(1, 16'h0100, 16'hff00, 16'h4000, 16'hc000, 0, 0);
        add_voice(1, 16'hffff, 16'h0001, 16'h8000, 16'h0001, 0, 1);
        // small negative products round toward minus infinity
        add_voice(1, 16'hffff, 16'hffff, 16'h0001, 16'h0000, 1, 1);
        add_voice(1, 16'hfffe, 16'h0003, 16'h7fff, 16'hffff, 1, 1);
        // voices that never emit, then a start in the middle of a run
        add_voice(1, 16'h5555, 16'haaaa, 16'h8000, 16'h4000, 1, 0);
        add_voice(1, 16'haaaa, 16'h5555, 16'h8000, 16'hc000, 1, 0);
        add_voice(1, 16'h0fff, 16'hf001, 16'h8000, 16'h0000, 0, 1);

        while (voice_q.size() < RAND_VOICES) begin
            if ($urandom_range(0, 99) < 85) add_random_frame();
            else add_noise();
        end
        // close the last open frame
        add_voice(1, pick_sample(), pick_sample(), pick_volume(), pick_pan(), 0, 1);

        wait (voice_q.size() == 0 && !s_valid);
        wait (frame_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (frame_q.size() != 0) begin
            $display("%0t: %0d expected frames never arrived", $time, frame_q.size());
            n_err += frame_q.size();
        end
        $display("mixed %0d voice transactions into %0d frames, %0d saturating adds",
                 voices_in, frames_out, clip_cnt);
        $display("long output hold-off applied: %0d, errors: %0d", hold_done, n_err);
        if (n_err == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
